// ===== src/wireframe_point_transform_defines.svh =====
// Assertion helpers shared by the point transform RTL.
`ifndef WIREFRAME_POINT_TRANSFORM_DEFINES_SVH
`define WIREFRAME_POINT_TRANSFORM_DEFINES_SVH

// Next-cycle implication, masked while reset is high.
`define WPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wireframe_point_transform: assertion failed");

// Next-cycle implication that is also checked across reset.
`define WPT_ASSERT_NEXT_NR(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("wireframe_point_transform: assertion failed");

`endif

// ===== src/wpt_pkg.sv =====
`timescale 1ns / 1ps

package wpt_pkg;

   // field widths
   localparam int STEP_W         = 8;
   localparam int STEP_CNT       = 1 << STEP_W;
   localparam int XY_SCALE_W     = 12;
   localparam int HEIGHT_SCALE_W = 10;
   localparam int OFFSET_W       = 11;
   localparam int PIVOT_W        = 23;
   localparam int OUT_W          = 24;

   // datapath widths
   localparam int TRIG_W  = 16;   // Q2.14
   localparam int FRAC_W  = 14;
   localparam int XY_W    = 23;   // scaled column / row
   localparam int ZS_W    = 26;   // scaled height
   localparam int COORD_W = 28;   // rotated coordinates
   localparam int SAT_W   = 48;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;
   localparam logic signed [SAT_W-1:0]  SAT_HI   = 48'sd8388607;
   localparam logic signed [SAT_W-1:0]  SAT_LO   = -48'sd8388608;

   typedef enum logic [2:0] {
      REG_XY_SCALE,
      REG_HEIGHT_SCALE,
      REG_ORIGIN_OFFSET,
      REG_PITCH_STEPS,
      REG_YAW_STEPS,
      REG_PIVOT_X,
      REG_PIVOT_Y,
      REG_PIVOT_Z
   } reg_index_type;

   typedef struct packed {
      logic [9:0]         grid_col;
      logic [9:0]         grid_row;
      logic signed [15:0] grid_height;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] screen_u;
      logic signed [OUT_W-1:0] screen_v;
      logic signed [OUT_W-1:0] depth_z;
   } rsp_word_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_val;
      logic signed [TRIG_W-1:0] sin_val;
   } trig_type;

   typedef logic signed [TRIG_W-1:0] trig_tab_type [STEP_CNT];

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[OUT_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== src/wpt_trig.sv =====
`timescale 1ns / 1ps
`include "wireframe_point_transform_defines.svh"

module wpt_trig import wpt_pkg::*; #(
   parameter int STEPS_PER_TURN = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [STEP_W-1:0] pitch_steps,
   input  logic [STEP_W-1:0] yaw_steps,
   output trig_type          pitch_trig,
   output trig_type          yaw_trig
);

   // angles in Q30 radians
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint PI_HALF_Q30 = 64'sd1686629713;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint TAYLOR_DIV [5] = '{64'sd110, 64'sd72, 64'sd42, 64'sd20, 64'sd6};

   // Taylor series to x^11 after folding to the first quadrant
   function automatic logic signed [TRIG_W-1:0] sin_q14(input longint ang);
      longint x;
      longint x2;
      longint t;
      longint s;
      longint r;
      logic   neg;
      int     k;
      x   = ang;
      neg = 1'b0;
      if (x > PI_Q30) begin
         neg = 1'b1;
         x   = TWO_PI_Q30 - x;
      end
      if (x > PI_HALF_Q30) begin
         x = PI_Q30 - x;
      end
      x2 = (x * x) >>> 30;
      t  = ONE_Q30;
      for (k = 0; k < 5; k++) begin
         t = ONE_Q30 - ((x2 * t) >>> 30) / TAYLOR_DIV[3'(k)];
      end
      s = (x * t) >>> 30;
      r = (s + 64'sd32768) >>> 16;
      if (r > 64'sd16384) begin
         r = 64'sd16384;
      end
      if (neg) begin
         r = -r;
      end
      return r[TRIG_W-1:0];
   endfunction

   function automatic trig_tab_type build_tab(input logic want_cos);
      trig_tab_type tab;
      longint       ang;
      longint       xc;
      int           i;
      for (i = 0; i < STEP_CNT; i++) begin
         ang = longint'(i % STEPS_PER_TURN) * TWO_PI_Q30 / STEPS_PER_TURN;
         if (!want_cos) begin
            tab[STEP_W'(i)] = sin_q14(ang);
         end else if ((i % STEPS_PER_TURN) == 0) begin
            // zero phase is an exact identity rotation
            tab[STEP_W'(i)] = TRIG_ONE;
         end else begin
            xc = ang + PI_HALF_Q30;
            if (xc >= TWO_PI_Q30) begin
               xc = xc - TWO_PI_Q30;
            end
            tab[STEP_W'(i)] = sin_q14(xc);
         end
      end
      return tab;
   endfunction

   localparam trig_tab_type SIN_TAB = build_tab(1'b0);
   localparam trig_tab_type COS_TAB = build_tab(1'b1);

   trig_type pitch_trig_ff;
   trig_type yaw_trig_ff;

   logic pitch_ident;
   logic yaw_ident;

   always_ff @(posedge clock) begin
      pitch_trig_ff.cos_val <= COS_TAB[pitch_steps];
      pitch_trig_ff.sin_val <= SIN_TAB[pitch_steps];
      yaw_trig_ff.cos_val   <= COS_TAB[yaw_steps];
      yaw_trig_ff.sin_val   <= SIN_TAB[yaw_steps];
   end

   assign pitch_trig = pitch_trig_ff;
   assign yaw_trig   = yaw_trig_ff;

   assign pitch_ident = (pitch_trig.cos_val == TRIG_ONE) && (pitch_trig.sin_val == '0);
   assign yaw_ident   = (yaw_trig.cos_val == TRIG_ONE) && (yaw_trig.sin_val == '0);

   `WPT_ASSERT_NEXT(a_pitch_zero_identity, clock, reset, pitch_steps == '0, pitch_ident)
   `WPT_ASSERT_NEXT(a_yaw_zero_identity, clock, reset, yaw_steps == '0, yaw_ident)

endmodule

// ===== src/wpt_rotate.sv =====
`timescale 1ns / 1ps

// Rotation of (a, b) about (pivot_a, pivot_b):
//   a' = trunc((c*da - s*db + pivot_a*2^14) / 2^14)
//   b' = trunc((s*da + c*db + pivot_b*2^14) / 2^14)
// Stage 1: differences and products. Stage 2: sums and truncation.
module wpt_rotate import wpt_pkg::*; #(
   parameter int A_W    = 23,
   parameter int B_W    = 26,
   parameter int SIDE_W = 23
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  trig_type                  trig,
   input  logic                      in_vld,
   input  logic signed [A_W-1:0]     a,
   input  logic signed [B_W-1:0]     b,
   input  logic signed [PIVOT_W-1:0] pivot_a,
   input  logic signed [PIVOT_W-1:0] pivot_b,
   input  logic [SIDE_W-1:0]         side,
   output logic                      out_vld,
   output logic signed [COORD_W-1:0] a_out,
   output logic signed [COORD_W-1:0] b_out,
   output logic [SIDE_W-1:0]         side_out
);

   localparam int AB_W   = (A_W > B_W) ? A_W : B_W;
   localparam int IN_W   = (AB_W > PIVOT_W) ? AB_W : PIVOT_W;
   localparam int D_W    = IN_W + 1;
   localparam int PROD_W = TRIG_W + D_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << FRAC_W) - 1);
   localparam logic signed [SUM_W-1:0] NO_BIAS    = SUM_W'(0);

   logic signed [D_W-1:0]     da;
   logic signed [D_W-1:0]     db;
   logic signed [PROD_W-1:0]  ca_in, sb_in, sa_in, cb_in;
   logic signed [PROD_W-1:0]  ca_ff, sb_ff, sa_ff, cb_ff;
   logic                      mid_vld_ff;
   logic [SIDE_W-1:0]         side_mid_ff;

   logic signed [SUM_W-1:0]   sum_a, sum_b;
   logic signed [SUM_W-1:0]   bias_a, bias_b;
   logic signed [SUM_W-1:0]   quo_a, quo_b;
   logic signed [COORD_W-1:0] a_out_in, b_out_in;
   logic signed [COORD_W-1:0] a_out_ff, b_out_ff;
   logic                      out_vld_ff;
   logic [SIDE_W-1:0]         side_out_ff;

   always_comb begin
      da    = D_W'(a) - D_W'(pivot_a);
      db    = D_W'(b) - D_W'(pivot_b);
      ca_in = PROD_W'(trig.cos_val) * PROD_W'(da);
      sb_in = PROD_W'(trig.sin_val) * PROD_W'(db);
      sa_in = PROD_W'(trig.sin_val) * PROD_W'(da);
      cb_in = PROD_W'(trig.cos_val) * PROD_W'(db);
   end

   always_comb begin
      sum_a    = SUM_W'(ca_ff) - SUM_W'(sb_ff) + (SUM_W'(pivot_a) <<< FRAC_W);
      sum_b    = SUM_W'(sa_ff) + SUM_W'(cb_ff) + (SUM_W'(pivot_b) <<< FRAC_W);
      // round toward zero
      bias_a   = sum_a[SUM_W-1] ? TRUNC_BIAS : NO_BIAS;
      bias_b   = sum_b[SUM_W-1] ? TRUNC_BIAS : NO_BIAS;
      quo_a    = (sum_a + bias_a) >>> FRAC_W;
      quo_b    = (sum_b + bias_b) >>> FRAC_W;
      a_out_in = quo_a[COORD_W-1:0];
      b_out_in = quo_b[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         mid_vld_ff <= in_vld;
         out_vld_ff <= mid_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ca_ff       <= ca_in;
         sb_ff       <= sb_in;
         sa_ff       <= sa_in;
         cb_ff       <= cb_in;
         side_mid_ff <= side;
         a_out_ff    <= a_out_in;
         b_out_ff    <= b_out_in;
         side_out_ff <= side_mid_ff;
      end
   end

   assign out_vld  = out_vld_ff;
   assign a_out    = a_out_ff;
   assign b_out    = b_out_ff;
   assign side_out = side_out_ff;

endmodule

// ===== src/wpt_project.sv =====
`timescale 1ns / 1ps
`include "wireframe_point_transform_defines.svh"

// Isometric projection and output saturation.
// Stage 1: u/v sums and the 1/sqrt2, 1/sqrt6 products. Stage 2: truncation,
// saturation, output register.
module wpt_project import wpt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_vld,
   input  logic signed [COORD_W-1:0] x,
   input  logic signed [COORD_W-1:0] y,
   input  logic signed [COORD_W-1:0] z,
   output logic                      out_vld,
   output rsp_word_type              out_word
);

   localparam int SU_W   = COORD_W + 1;
   localparam int SV_W   = COORD_W + 3;
   localparam int PROD_W = SAT_W;
   localparam int SCALE_SHIFT = 16;
   localparam logic signed [PROD_W-1:0] INV_SQRT2_Q16 = PROD_W'(46341);
   localparam logic signed [PROD_W-1:0] INV_SQRT6_Q16 = PROD_W'(26755);
   localparam logic signed [PROD_W-1:0] TRUNC_BIAS    = PROD_W'((1 << SCALE_SHIFT) - 1);
   localparam logic signed [PROD_W-1:0] NO_BIAS       = PROD_W'(0);

   logic signed [SU_W-1:0]    su;
   logic signed [SV_W-1:0]    sv;
   logic signed [PROD_W-1:0]  pu_in, pv_in;
   logic signed [PROD_W-1:0]  pu_ff, pv_ff;
   logic signed [COORD_W-1:0] z_mid_ff;
   logic                      mid_vld_ff;

   logic signed [PROD_W-1:0]  bias_u, bias_v;
   logic signed [PROD_W-1:0]  qu, qv;
   rsp_word_type              out_in;
   rsp_word_type              out_ff;
   logic                      out_vld_ff;

   always_comb begin
      su    = SU_W'(x) + SU_W'(z);
      sv    = SV_W'(x) + (SV_W'(y) <<< 1) - SV_W'(z);
      pu_in = PROD_W'(su) * INV_SQRT2_Q16;
      pv_in = PROD_W'(sv) * INV_SQRT6_Q16;
   end

   always_comb begin
      bias_u          = pu_ff[PROD_W-1] ? TRUNC_BIAS : NO_BIAS;
      bias_v          = pv_ff[PROD_W-1] ? TRUNC_BIAS : NO_BIAS;
      qu              = (pu_ff + bias_u) >>> SCALE_SHIFT;
      qv              = (pv_ff + bias_v) >>> SCALE_SHIFT;
      out_in.screen_u = sat_out(qu);
      out_in.screen_v = sat_out(qv);
      out_in.depth_z  = sat_out(SAT_W'(z_mid_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         mid_vld_ff <= in_vld;
         out_vld_ff <= mid_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pu_ff    <= pu_in;
         pv_ff    <= pv_in;
         z_mid_ff <= z;
         out_ff   <= out_in;
      end
   end

   assign out_vld  = out_vld_ff;
   assign out_word = out_ff;

   `WPT_ASSERT_NEXT(a_no_phantom_word, clock, reset, en && !mid_vld_ff, !out_vld_ff)

endmodule

// ===== src/wireframe_point_transform.sv =====
// Pipeline stages: scale 1, pitch 2, yaw 2, project 2, from req word accept to rsp_valid.
// Throughput: one word per cycle; the seven stages advance together whenever the
// output register is empty or being taken, so a stall holds every stage in place.
// Trig values for a new angle are ready in the cycle after its register write.
// Reset (synchronous, active high) empties the pipeline and loads register defaults.
`timescale 1ns / 1ps
`include "wireframe_point_transform_defines.svh"

module wireframe_point_transform import wpt_pkg::*; #(
   parameter int STEPS_PER_TURN = 256
) (
   input  logic              clock,
   input  logic              reset,

   // vertex words in
   input  logic              req_valid,
   output logic              req_ready,
   input  req_word_type      req_data,

   // screen-space words out
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_word_type      rsp_data,

   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   //------------------------------------------------------------------
   // Registers, one per 32-bit word
   //------------------------------------------------------------------
   logic [XY_SCALE_W-1:0]            xy_scale_ff;
   logic signed [HEIGHT_SCALE_W-1:0] height_scale_ff;
   logic [OFFSET_W-1:0]              origin_offset_ff;
   logic [STEP_W-1:0]                pitch_steps_ff;
   logic [STEP_W-1:0]                yaw_steps_ff;
   logic signed [PIVOT_W-1:0]        pivot_x_ff;
   logic signed [PIVOT_W-1:0]        pivot_y_ff;
   logic signed [PIVOT_W-1:0]        pivot_z_ff;

   logic          csr_write;
   reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = reg_index_type'(paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         xy_scale_ff      <= XY_SCALE_W'(1);
         height_scale_ff  <= HEIGHT_SCALE_W'(1);
         origin_offset_ff <= '0;
         pitch_steps_ff   <= '0;
         yaw_steps_ff     <= '0;
         pivot_x_ff       <= '0;
         pivot_y_ff       <= '0;
         pivot_z_ff       <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_XY_SCALE:      xy_scale_ff      <= pwdata[XY_SCALE_W-1:0];
            REG_HEIGHT_SCALE:  height_scale_ff  <= pwdata[HEIGHT_SCALE_W-1:0];
            REG_ORIGIN_OFFSET: origin_offset_ff <= pwdata[OFFSET_W-1:0];
            REG_PITCH_STEPS:   pitch_steps_ff   <= pwdata[STEP_W-1:0];
            REG_YAW_STEPS:     yaw_steps_ff     <= pwdata[STEP_W-1:0];
            REG_PIVOT_X:       pivot_x_ff       <= pwdata[PIVOT_W-1:0];
            REG_PIVOT_Y:       pivot_y_ff       <= pwdata[PIVOT_W-1:0];
            REG_PIVOT_Z:       pivot_z_ff       <= pwdata[PIVOT_W-1:0];
            default: ;
         endcase
      end
   end

   // read back; signed registers come back sign-extended
   always_comb begin
      case (csr_index)
         REG_XY_SCALE:      prdata = DATA_W'(xy_scale_ff);
         REG_HEIGHT_SCALE:  prdata = DATA_W'(height_scale_ff);
         REG_ORIGIN_OFFSET: prdata = DATA_W'(origin_offset_ff);
         REG_PITCH_STEPS:   prdata = DATA_W'(pitch_steps_ff);
         REG_YAW_STEPS:     prdata = DATA_W'(yaw_steps_ff);
         REG_PIVOT_X:       prdata = DATA_W'(pivot_x_ff);
         REG_PIVOT_Y:       prdata = DATA_W'(pivot_y_ff);
         REG_PIVOT_Z:       prdata = DATA_W'(pivot_z_ff);
         default:           prdata = '0;
      endcase
   end

   //------------------------------------------------------------------
   // Pipeline advance: every stage moves when the output register is
   // free or its word leaves this cycle.
   //------------------------------------------------------------------
   logic en;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   //------------------------------------------------------------------
   // Sine / cosine lookup for both angles (constant tables, registered)
   //------------------------------------------------------------------
   trig_type pitch_trig;
   trig_type yaw_trig;

   wpt_trig #(
      .STEPS_PER_TURN (STEPS_PER_TURN)
   ) u_trig (
      .clock       (clock),
      .reset       (reset),
      .pitch_steps (pitch_steps_ff),
      .yaw_steps   (yaw_steps_ff),
      .pitch_trig  (pitch_trig),
      .yaw_trig    (yaw_trig)
   );

   //------------------------------------------------------------------
   // Stage 1: x = col*scale + offset, y = row*scale + offset,
   // z = height*height_scale. x and y never exceed 22 bits.
   //------------------------------------------------------------------
   logic signed [XY_W-1:0] x_in, y_in, x_ff, y_ff;
   logic signed [ZS_W-1:0] z_in, z_ff;
   logic                   scale_vld_ff;

   always_comb begin
      x_in = XY_W'(req_data.grid_col) * XY_W'(xy_scale_ff) + XY_W'(origin_offset_ff);
      y_in = XY_W'(req_data.grid_row) * XY_W'(xy_scale_ff) + XY_W'(origin_offset_ff);
      z_in = ZS_W'(req_data.grid_height) * ZS_W'(height_scale_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_vld_ff <= 1'b0;
      end else if (en) begin
         scale_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   //------------------------------------------------------------------
   // Stages 2-3: pitch, rotate (y, z) about (pivot_y, pivot_z); x rides along
   //------------------------------------------------------------------
   logic                      pitch_vld;
   logic signed [COORD_W-1:0] y_p, z_p;
   logic [XY_W-1:0]           x_p;

   wpt_rotate #(
      .A_W    (XY_W),
      .B_W    (ZS_W),
      .SIDE_W (XY_W)
   ) u_pitch (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .trig     (pitch_trig),
      .in_vld   (scale_vld_ff),
      .a        (y_ff),
      .b        (z_ff),
      .pivot_a  (pivot_y_ff),
      .pivot_b  (pivot_z_ff),
      .side     (x_ff),
      .out_vld  (pitch_vld),
      .a_out    (y_p),
      .b_out    (z_p),
      .side_out (x_p)
   );

   //------------------------------------------------------------------
   // Stages 4-5: yaw, rotate (z, x) about (pivot_z, pivot_x); this order
   // gives z' = c*dz - s*dx and x' = s*dz + c*dx. y rides along.
   //------------------------------------------------------------------
   logic                      yaw_vld;
   logic signed [COORD_W-1:0] z_r, x_r;
   logic [COORD_W-1:0]        y_r;

   wpt_rotate #(
      .A_W    (COORD_W),
      .B_W    (XY_W),
      .SIDE_W (COORD_W)
   ) u_yaw (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .trig     (yaw_trig),
      .in_vld   (pitch_vld),
      .a        (z_p),
      .b        (signed'(x_p)),
      .pivot_a  (pivot_z_ff),
      .pivot_b  (pivot_x_ff),
      .side     (y_p),
      .out_vld  (yaw_vld),
      .a_out    (z_r),
      .b_out    (x_r),
      .side_out (y_r)
   );

   //------------------------------------------------------------------
   // Stages 6-7: projection, saturation, output register
   //------------------------------------------------------------------
   wpt_project u_project (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (yaw_vld),
      .x        (x_r),
      .y        (signed'(y_r)),
      .z        (z_r),
      .out_vld  (rsp_valid),
      .out_word (rsp_data)
   );

   //------------------------------------------------------------------
   // Checks
   //------------------------------------------------------------------
   logic [3:0] pipe_vld;

   assign pipe_vld = {scale_vld_ff, pitch_vld, yaw_vld, rsp_valid};

   `WPT_ASSERT_NEXT_NR(a_reset_empties_pipe, clock, reset, pipe_vld == '0)
   `WPT_ASSERT_NEXT(a_stall_freezes_pipe, clock, reset, rsp_valid && !rsp_ready, $stable(pipe_vld))

endmodule

// ===== bench/wireframe_point_transform_tb.sv =====
`timescale 1ns / 1ps

module wireframe_point_transform_tb;
   import wpt_pkg::*;

   // pipeline depth from the block header; used for quiet time after a drain
   localparam int PIPE_LATENCY = 7;
   // cycle limit for the whole run, many times over what the slowest run needs
   localparam int CYCLE_LIMIT  = 400000;

   // fixed-point constants of the transform (radians in Q30)
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint Q14_ONE     = 64'sd16384;
   localparam longint Q16_ONE     = 64'sd65536;
   localparam longint INV_SQRT2   = 64'sd46341;
   localparam longint INV_SQRT6   = 64'sd26755;
   localparam longint SCREEN_MAX  = 64'sd8388607;
   localparam longint SCREEN_MIN  = -64'sd8388608;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_word_type      req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_word_type      rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   wireframe_point_transform dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // shadow copy of the register file, updated on each completed write
   logic [11:0]        cfg_xy_scale;
   logic signed [9:0]  cfg_height_scale;
   logic [10:0]        cfg_origin;
   logic [7:0]         cfg_pitch;
   logic [7:0]         cfg_yaw;
   logic signed [22:0] cfg_pivot_x;
   logic signed [22:0] cfg_pivot_y;
   logic signed [22:0] cfg_pivot_z;

   // screen words predicted for accepted vertices, oldest first
   rsp_word_type pending_screen[$];

   int error_count   = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int stall_left    = 0;   // long receiver hold-off, counted down by the sink

   // ---------------------------------------------------------------------
   // clock, cycle limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   function automatic longint taylor_div(int k);
      longint d;
      case (k)
         0: d = 110;
         1: d = 72;
         2: d = 42;
         3: d = 20;
         default: d = 6;
      endcase
      return d;
   endfunction

   // sine in Q2.14 of an angle in Q30 radians, 0 <= ang < 2pi
   function automatic longint sine_q14(longint ang);
      longint a, a2, t, s, r;
      bit     neg;
      a   = ang;
      neg = 1'b0;
      // fold into the first quadrant
      if (a > PI_Q30) begin
         neg = 1'b1;
         a   = TWO_PI_Q30 - a;
      end
      if (a > HALF_PI_Q30) a = PI_Q30 - a;
      a2 = (a * a) >>> 30;
      t  = ONE_Q30;
      // Horner form of the series up to x^11, truncating divisions
      for (int k = 0; k < 5; k++) t = ONE_Q30 - ((a2 * t) >>> 30) / taylor_div(k);
      s = (a * t) >>> 30;
      r = (s + 32768) >>> 16;
      if (r > Q14_ONE) r = Q14_ONE;
      return neg ? -r : r;
   endfunction

   function automatic longint cosine_q14(longint ang);
      longint ac;
      ac = ang + HALF_PI_Q30;
      if (ac >= TWO_PI_Q30) ac -= TWO_PI_Q30;
      return sine_q14(ac);
   endfunction

   function automatic longint turn_angle(logic [7:0] steps);
      longint p;
      p = longint'(steps);   // register width equals one turn, so no modulo needed
      return p * TWO_PI_Q30 / STEP_CNT;
   endfunction

   function automatic logic signed [OUT_W-1:0] clamp_screen(longint v);
      longint c;
      c = v;
      if (c > SCREEN_MAX) c = SCREEN_MAX;
      if (c < SCREEN_MIN) c = SCREEN_MIN;
      return c[OUT_W-1:0];
   endfunction

   // full transform of one vertex under the current shadow registers
   function automatic rsp_word_type project_vertex(req_word_type w);
      longint       x, y, z, nx, ny, nz, c, s, px, py, pz, ang, u, v, gain;
      rsp_word_type r;
      px   = longint'(cfg_pivot_x);
      py   = longint'(cfg_pivot_y);
      pz   = longint'(cfg_pivot_z);
      gain = longint'(cfg_xy_scale);
      x    = longint'(w.grid_col);
      y    = longint'(w.grid_row);
      x    = x * gain + longint'(cfg_origin);
      y    = y * gain + longint'(cfg_origin);
      z    = longint'(w.grid_height);
      gain = longint'(cfg_height_scale);
      z    = z * gain;
      // pitch: about x; zero phase leaves the point untouched
      if (cfg_pitch != 0) begin
         ang = turn_angle(cfg_pitch);
         c   = cosine_q14(ang);
         s   = sine_q14(ang);
         ny  = (c * (y - py) - s * (z - pz) + py * Q14_ONE) / Q14_ONE;
         nz  = (s * (y - py) + c * (z - pz) + pz * Q14_ONE) / Q14_ONE;
         y   = ny;
         z   = nz;
      end
      // yaw: about y, applied to the pitched point
      if (cfg_yaw != 0) begin
         ang = turn_angle(cfg_yaw);
         c   = cosine_q14(ang);
         s   = sine_q14(ang);
         nx  = (c * (x - px) + s * (z - pz) + px * Q14_ONE) / Q14_ONE;
         nz  = (c * (z - pz) - s * (x - px) + pz * Q14_ONE) / Q14_ONE;
         x   = nx;
         z   = nz;
      end
      u = (x + z) * INV_SQRT2 / Q16_ONE;
      v = (x + 2 * y - z) * INV_SQRT6 / Q16_ONE;
      r.screen_u = clamp_screen(u);
      r.screen_v = clamp_screen(v);
      r.depth_z  = clamp_screen(z);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // result sink: random idling plus an optional long hold-off
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  = 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // compare every taken word against the oldest prediction
   always @(posedge clock) begin : check_screen
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_screen.size() == 0) begin
            $error("unexpected screen word u=%0d v=%0d z=%0d",
                   rsp_data.screen_u, rsp_data.screen_v, rsp_data.depth_z);
            error_count++;
         end else begin
            want = pending_screen.pop_front();
            if (rsp_data.screen_u !== want.screen_u) begin
               $error("screen_u: expected %0d, got %0d", want.screen_u, rsp_data.screen_u);
               error_count++;
            end
            if (rsp_data.screen_v !== want.screen_v) begin
               $error("screen_v: expected %0d, got %0d", want.screen_v, rsp_data.screen_v);
               error_count++;
            end
            if (rsp_data.depth_z !== want.depth_z) begin
               $error("depth_z: expected %0d, got %0d", want.depth_z, rsp_data.depth_z);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   // offer one vertex word, with random idle cycles ahead of it
   task automatic offer_vertex(input logic [9:0] col, input logic [9:0] row,
                               input logic signed [15:0] height);
      req_word_type w;
      w.grid_col    = col;
      w.grid_row    = row;
      w.grid_height = height;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = w;
      do @(posedge clock); while (!req_ready);
      pending_screen.push_back(project_vertex(w));
   endtask

   // random vertex with the field extremes mixed in
   task automatic offer_random_vertex();
      logic [9:0]         col, row;
      logic signed [15:0] height;
      case ($urandom_range(7))
         0:       col = '0;
         1:       col = 10'd1023;
         default: col = 10'($urandom_range(1023));
      endcase
      case ($urandom_range(7))
         0:       row = '0;
         1:       row = 10'd1023;
         default: row = 10'($urandom_range(1023));
      endcase
      case ($urandom_range(7))
         0:       height = -16'sd32768;
         1:       height = 16'sd32767;
         2:       height = 16'(int'($urandom_range(200)) - 100);
         default: height = 16'($urandom);
      endcase
      offer_vertex(col, row, height);
   endtask

   // drop valid, then wait until every predicted word has been taken
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_screen.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // register write: setup cycle, then access cycle until pready
   task automatic write_reg(input reg_index_type r, input logic [DATA_W-1:0] v);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {r, 2'b00};
      pwdata  = v;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (r)
         REG_XY_SCALE:      cfg_xy_scale     = v[11:0];
         REG_HEIGHT_SCALE:  cfg_height_scale = v[9:0];
         REG_ORIGIN_OFFSET: cfg_origin       = v[10:0];
         REG_PITCH_STEPS:   cfg_pitch        = v[7:0];
         REG_YAW_STEPS:     cfg_yaw          = v[7:0];
         REG_PIVOT_X:       cfg_pivot_x      = v[22:0];
         REG_PIVOT_Y:       cfg_pivot_y      = v[22:0];
         REG_PIVOT_Z:       cfg_pivot_z      = v[22:0];
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // random register value; junk above the field width is allowed
   function automatic logic [DATA_W-1:0] pick_reg_value(reg_index_type r);
      logic [DATA_W-1:0] v;
      int                pick;
      pick = $urandom_range(7);
      v    = $urandom;
      case (r)
         REG_XY_SCALE: begin
            if (pick == 0) v = 0;
            else if (pick == 1) v = 4095;
            else if (pick < 5) v = $urandom_range(16, 1);
         end
         REG_HEIGHT_SCALE: begin
            if (pick == 0) v = 32'h0000_0200;            // -512
            else if (pick == 1) v = 511;
            else if (pick < 5) v = $urandom_range(8) - 4;
         end
         REG_ORIGIN_OFFSET: begin
            if (pick == 0) v = 0;
            else if (pick == 1) v = 2047;
         end
         REG_PITCH_STEPS, REG_YAW_STEPS: begin
            if (pick == 0) v = 0;                          // rotation skipped
            else if (pick == 1) v = 255;
            else if (pick == 2) v = $urandom_range(3) * 64; // quarter turns
         end
         default: begin                                     // pivots
            if (pick == 0) v = 32'hFFC0_0000;              // most negative
            else if (pick == 1) v = 32'h003F_FFFF;
            else if (pick < 5) v = $urandom_range(2000) - 1000;
         end
      endcase
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   // reset registers: identity scale, no rotation; field extremes and patterns
   task automatic test_reset_defaults();
      offer_vertex(10'd0,    10'd0,    16'sd0);
      offer_vertex(10'd1023, 10'd1023, 16'sd32767);
      offer_vertex(10'd1023, 10'd0,    -16'sd32768);
      offer_vertex(10'd0,    10'd1023, -16'sd1);
      offer_vertex(10'h2AA,  10'h155,  16'sh5555);
      offer_vertex(10'h155,  10'h2AA,  -16'sh5556);
      wait_drained();
   endtask

   // biggest scales and offset with no rotation: drives every output into saturation
   task automatic test_saturation_extremes();
      write_reg(REG_XY_SCALE,      32'd4095);
      write_reg(REG_HEIGHT_SCALE,  32'd511);
      write_reg(REG_ORIGIN_OFFSET, 32'd2047);
      offer_vertex(10'd1023, 10'd1023, 16'sd32767);
      offer_vertex(10'd1023, 10'd1023, -16'sd32768);
      offer_vertex(10'd0,    10'd0,    16'sd0);
      offer_vertex(10'd1023, 10'd0,    -16'sd32768);
      wait_drained();
   endtask

   // collapsed grid, negative gain, quarter-turn angles around far pivots,
   // then single-step angles near zero and a full turn
   task automatic test_rotation_extremes();
      write_reg(REG_XY_SCALE,      32'd0);
      write_reg(REG_HEIGHT_SCALE,  32'h0000_0200);
      write_reg(REG_ORIGIN_OFFSET, 32'd0);
      write_reg(REG_PITCH_STEPS,   32'd64);
      write_reg(REG_YAW_STEPS,     32'd192);
      write_reg(REG_PIVOT_X,       32'h003F_FFFF);
      write_reg(REG_PIVOT_Y,       32'hFFC0_0000);
      write_reg(REG_PIVOT_Z,       32'h003F_FFFF);
      offer_vertex(10'd1023, 10'd0,    16'sd32767);
      offer_vertex(10'd0,    10'd1023, -16'sd32768);
      offer_vertex(10'd512,  10'd512,  -16'sd1);
      wait_drained();
      write_reg(REG_XY_SCALE,     32'd1);
      write_reg(REG_HEIGHT_SCALE, 32'd1);
      write_reg(REG_PITCH_STEPS,  32'd1);
      write_reg(REG_YAW_STEPS,    32'd255);
      write_reg(REG_PIVOT_X,      32'd100);
      write_reg(REG_PIVOT_Y,      -32'sd100);
      write_reg(REG_PIVOT_Z,      32'd0);
      offer_vertex(10'd1023, 10'd1,    16'sd1000);
      offer_vertex(10'd3,    10'd1023, -16'sd1000);
      offer_vertex(10'd77,   10'd600,  16'sd0);
      wait_drained();
   endtask

   // random register sets, each followed by a burst of random vertices
   task automatic test_random_traffic(input int sets, input int per_set,
                                      input int send_pct, input int rsp_pct);
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      for (int i = 0; i < sets; i++) begin
         for (int r = 0; r < 8; r++) begin
            write_reg(reg_index_type'(r), pick_reg_value(reg_index_type'(r)));
         end
         repeat (per_set) offer_random_vertex();
         wait_drained();
      end
   endtask

   // sink holds off long enough for the pipeline to fill and stall req_ready
   task automatic test_input_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 20;
      for (int r = 0; r < 8; r++) begin
         write_reg(reg_index_type'(r), pick_reg_value(reg_index_type'(r)));
      end
      @(posedge clock);
      stall_left = 250;
      repeat (40) offer_random_vertex();
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      // shadow registers at their reset values
      cfg_xy_scale     = 12'd1;
      cfg_height_scale = 10'sd1;
      cfg_origin       = '0;
      cfg_pitch        = '0;
      cfg_yaw          = '0;
      cfg_pivot_x      = '0;
      cfg_pivot_y      = '0;
      cfg_pivot_z      = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_saturation_extremes();
      test_rotation_extremes();
      test_random_traffic(5, 28, 9, 59);
      test_random_traffic(5, 28, 59, 9);
      test_random_traffic(5, 28, 0, 0);
      test_input_backpressure();

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/wpt_pkg.sv
src/wpt_trig.sv
src/wpt_rotate.sv
src/wpt_project.sv
src/wireframe_point_transform.sv
bench/wireframe_point_transform_tb.sv
